@@ rtl/pbbt_pkg.sv @@
// Shared types and constants for the pixel bounding-box trim block.
// Used by pbbt_cfg_regs, pbbt_tracker and pixel_bounding_box_trim_top.
package pbbt_pkg;

  localparam int DEF_MAX_DIM = 4096;
  localparam int DIM_REG_W   = 13;
  localparam int COORD_W     = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd4;

  // Bits of side_mask
  localparam int SIDE_LEFT   = 0;
  localparam int SIDE_TOP    = 1;
  localparam int SIDE_RIGHT  = 2;
  localparam int SIDE_BOTTOM = 3;

  // match_mode codes
  localparam logic MODE_ALPHA = 1'b0;
  localparam logic MODE_KEY   = 1'b1;

  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH  = 13'd1;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT = 13'd1;
  localparam logic [3:0]           RST_SIDE_MASK    = 4'hF;
  localparam logic                 RST_MATCH_MODE   = MODE_ALPHA;
  localparam logic [31:0]          RST_KEY_COLOR    = 32'h0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] bottom_row;
    logic               empty_frame;
    logic               no_trim;
  } box_t;

  // Match and trim controls handed from the register file to the tracker
  typedef struct packed {
    logic [3:0]  side_mask;
    logic        match_mode;
    logic [31:0] key_color;
  } match_cfg_t;

endpackage

@@ rtl/pbbt_cfg_regs.sv @@
// Configuration register file for the bounding-box trim block.
// Holds frame size and match controls; derives the clamped last column and row.
module pbbt_cfg_regs
  import pbbt_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int CW = $clog2(MAX_DIM)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CW-1:0]         last_col,
  output logic [CW-1:0]         last_row,
  output match_cfg_t            match_cfg
);

  logic [DIM_REG_W-1:0] frame_width;
  logic [DIM_REG_W-1:0] frame_height;
  logic [3:0]           side_mask;
  logic                 match_mode;
  logic [31:0]          key_color;

  // A size of zero acts as one, a size past MAX_DIM acts as MAX_DIM
  function automatic logic [CW-1:0] last_index(input logic [DIM_REG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = CW'(MAX_DIM - 1);
    end else begin
      r = CW'(v - 13'd1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      side_mask    <= RST_SIDE_MASK;
      match_mode   <= RST_MATCH_MODE;
      key_color    <= RST_KEY_COLOR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_REG_W-1:0];
        REG_SIDE_MASK:    side_mask    <= cfg_data[3:0];
        REG_MATCH_MODE:   match_mode   <= cfg_data[0];
        REG_KEY_COLOR:    key_color    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign last_col             = last_index(frame_width);
  assign last_row             = last_index(frame_height);
  assign match_cfg.side_mask  = side_mask;
  assign match_cfg.match_mode = match_mode;
  assign match_cfg.key_color  = key_color;

endmodule

@@ rtl/pbbt_tracker.sv @@
// Raster position and content extent tracker for the bounding-box trim block.
// Classifies one pixel per step, updates min/max extent and forms the frame result.
module pbbt_tracker
  import pbbt_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int CW = $clog2(MAX_DIM)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  pixel_t     pix,
  input  logic [CW-1:0] last_col,
  input  logic [CW-1:0] last_row,
  input  match_cfg_t match_cfg,
  output logic       frame_end,
  output box_t       box
);

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] min_column, min_column_next;
  logic [CW-1:0] min_row,    min_row_next;
  logic [CW-1:0] max_column, max_column_next;
  logic [CW-1:0] max_row,    max_row_next;
  logic          content_seen, content_seen_next;
  logic          content;
  logic          row_end;

  always_comb begin
    if (match_cfg.match_mode == MODE_KEY) begin
      content = {pix.red, pix.green, pix.blue, pix.alpha} != match_cfg.key_color;
    end else begin
      content = pix.alpha != 8'd0;
    end
  end

  // Extent including the current pixel; the result sees it too
  always_comb begin
    min_column_next   = min_column;
    max_column_next   = max_column;
    min_row_next      = min_row;
    max_row_next      = max_row;
    content_seen_next = content_seen;
    if (content) begin
      content_seen_next = 1'b1;
      if (!content_seen) begin
        min_column_next = column_count;
        max_column_next = column_count;
        min_row_next    = row_count;
        max_row_next    = row_count;
      end else begin
        if (column_count < min_column) min_column_next = column_count;
        if (column_count > max_column) max_column_next = column_count;
        if (row_count < min_row)       min_row_next    = row_count;
        if (row_count > max_row)       max_row_next    = row_count;
      end
    end
  end

  // Past-the-end positions after a size change also end the row or frame
  assign row_end   = column_count >= last_col;
  assign frame_end = row_end && (row_count >= last_row);

  always_comb begin
    box.left_col = (content_seen_next && match_cfg.side_mask[SIDE_LEFT])
                   ? COORD_W'(min_column_next) : '0;
    box.top_row  = (content_seen_next && match_cfg.side_mask[SIDE_TOP])
                   ? COORD_W'(min_row_next) : '0;
    box.right_col = (content_seen_next && match_cfg.side_mask[SIDE_RIGHT])
                    ? COORD_W'(max_column_next) : COORD_W'(last_col);
    box.bottom_row = (content_seen_next && match_cfg.side_mask[SIDE_BOTTOM])
                     ? COORD_W'(max_row_next) : COORD_W'(last_row);
    box.empty_frame = !content_seen_next;
    box.no_trim     = match_cfg.side_mask == 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      content_seen <= 1'b0;
    end else if (step) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
      content_seen <= frame_end ? 1'b0 : content_seen_next;
    end
  end

  // Extent registers are only read while content_seen is set
  always_ff @(posedge clk) begin
    if (step) begin
      min_column <= min_column_next;
      max_column <= max_column_next;
      min_row    <= min_row_next;
      max_row    <= max_row_next;
    end
  end

endmodule

@@ rtl/pixel_bounding_box_trim_top.sv @@
// Pixel bounding-box trim: takes RGBA pixels in raster order, one per clock, and
// on the last pixel of each frame delivers the trim rectangle of its content
// pixels (nonzero alpha, or not equal to the key color). Sustained rate is one
// pixel per clock; a pixel passes an input register and the extent update, and
// the frame result is registered into box as its last pixel leaves the input register.
// The only stall toward the source comes when a frame's last pixel meets a
// result still held in the output register. Configure only while idle.
module pixel_bounding_box_trim_top
  import pbbt_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  box_valid,
  input  logic                  box_stall,
  output box_t                  box,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_DIM);

  logic          pix_valid;
  pixel_t        pix;
  logic          step;
  logic          frame_end;
  logic          out_free;
  logic          pixel_take;
  box_t          box_next;
  logic [CW-1:0] last_col;
  logic [CW-1:0] last_row;
  match_cfg_t    match_cfg;

  assign cfg_ready = 1'b1;

  pbbt_cfg_regs #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .last_col  (last_col),
    .last_row  (last_row),
    .match_cfg (match_cfg)
  );

  pbbt_tracker #(.MAX_DIM(MAX_DIM)) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pix       (pix),
    .last_col  (last_col),
    .last_row  (last_row),
    .match_cfg (match_cfg),
    .frame_end (frame_end),
    .box       (box_next)
  );

  // Only a frame-ending pixel needs room in the output register
  assign out_free    = !box_valid || !box_stall;
  assign step        = pix_valid && (!frame_end || out_free);
  assign pixel_stall = pix_valid && !step;
  assign pixel_take  = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixel_take) begin
      pix_valid <= 1'b1;
    end else if (step) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      pix <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (step && frame_end) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame_end) begin
      box <= box_next;
    end
  end

`ifndef SYNTH
  // A frame result always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    step && frame_end |=> box_valid)
    else $error("frame result not presented");

  // Never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(step && frame_end && box_valid && box_stall))
    else $error("pending result overwritten");

  // A held pixel stays in the input register
  a_pixel_held: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !step |=> pix_valid && $stable(pix))
    else $error("held pixel lost");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for pixel_bounding_box_trim_top.
// Mirrors the frame tracker to predict each trim box and checks every result.
// Depends on pbbt_pkg and the RTL top module.
module tb_top;
  import pbbt_pkg::*;

  localparam int     MAX_DIM  = DEF_MAX_DIM;
  localparam longint LIMIT_NS = 64'd18_000_000;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel       = '0;
  logic                  box_valid;
  logic                  box_stall   = 1'b0;
  box_t                  box;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  pixel_bounding_box_trim_top uut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .box_valid   (box_valid),
    .box_stall   (box_stall),
    .box         (box),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Register shadow, as the block sees it
  logic [DIM_REG_W-1:0] reg_width  = RST_FRAME_WIDTH;
  logic [DIM_REG_W-1:0] reg_height = RST_FRAME_HEIGHT;
  logic [3:0]           reg_mask   = RST_SIDE_MASK;
  logic                 reg_mode   = RST_MATCH_MODE;
  logic [31:0]          reg_key    = RST_KEY_COLOR;

  // Frame tracker state
  logic [COORD_W-1:0] pos_col = '0;
  logic [COORD_W-1:0] pos_row = '0;
  logic [COORD_W-1:0] min_col = '1;
  logic [COORD_W-1:0] min_row = '1;
  logic [COORD_W-1:0] max_col = '0;
  logic [COORD_W-1:0] max_row = '0;
  logic               seen    = 1'b0;

  box_t   pending_boxes[$];
  pixel_t pixel_feed[$];

  int  px_pushed    = 0;
  int  px_accepted  = 0;
  int  boxes_seen   = 0;
  int  errors       = 0;
  int  src_stalls   = 0;
  int  settings     = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  int  holdoff_left = 0;
  bit  pix_fire     = 1'b0;
  bit  gaps_on      = 1'b1;
  bit  stalls_on    = 1'b1;

  function automatic logic [DIM_REG_W-1:0] eff_dim(logic [DIM_REG_W-1:0] v);
    if (v == '0) return DIM_REG_W'(1);
    if (v > MAX_DIM) return DIM_REG_W'(MAX_DIM);
    return v;
  endfunction

  // Advance position and extents by one pixel; queue a box on the frame's last pixel
  function automatic void track_pixel(pixel_t px);
    logic [DIM_REG_W-1:0] w;
    logic [DIM_REG_W-1:0] h;
    logic                 hit;
    box_t                 b;
    w = eff_dim(reg_width);
    h = eff_dim(reg_height);
    hit = (reg_mode == MODE_KEY) ? (px != reg_key) : (px.alpha != 8'h00);
    if (hit) begin
      if (!seen) begin
        min_col = pos_col;
        max_col = pos_col;
        min_row = pos_row;
        max_row = pos_row;
        seen    = 1'b1;
      end else begin
        if (pos_col < min_col) min_col = pos_col;
        if (pos_col > max_col) max_col = pos_col;
        if (pos_row < min_row) min_row = pos_row;
        if (pos_row > max_row) max_row = pos_row;
      end
    end
    if ({1'b0, pos_col} >= w - 1'b1) begin
      pos_col = '0;
      if ({1'b0, pos_row} >= h - 1'b1) begin
        b.left_col    = (seen && reg_mask[SIDE_LEFT])   ? min_col : '0;
        b.top_row     = (seen && reg_mask[SIDE_TOP])    ? min_row : '0;
        b.right_col   = (seen && reg_mask[SIDE_RIGHT])  ? max_col : COORD_W'(w - 1'b1);
        b.bottom_row  = (seen && reg_mask[SIDE_BOTTOM]) ? max_row : COORD_W'(h - 1'b1);
        b.empty_frame = !seen;
        b.no_trim     = (reg_mask == 4'h0);
        pending_boxes.push_back(b);
        pos_row = '0;
        min_col = '1;
        min_row = '1;
        max_col = '0;
        max_row = '0;
        seen    = 1'b0;
      end else begin
        pos_row = pos_row + 1'b1;
      end
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Background or content pixel under the current mode and key
  function automatic pixel_t make_pixel(bit hit);
    pixel_t      p;
    logic [31:0] flip;
    if (reg_mode == MODE_KEY) begin
      if (!hit) return reg_key;
      if ($urandom_range(0, 1) == 1) begin
        flip = 32'h1 << $urandom_range(0, 31);
      end else begin
        flip = $urandom;
        if (flip == '0) flip = 32'h1;
      end
      return reg_key ^ flip;
    end
    p = $urandom;
    p.alpha = hit ? 8'($urandom_range(1, 255)) : 8'h00;
    return p;
  endfunction

  // Monitor: check box transactions, track accepted pixel transactions
  always @(posedge clk) begin : monitor
    box_t want;
    pix_fire = !rst && pixel_valid && !pixel_stall;
    if (!rst) begin
      if (pixel_valid && pixel_stall) src_stalls++;
      if (box_valid && !box_stall) begin
        boxes_seen++;
        if (pending_boxes.size() == 0) begin
          errors++;
          $display("%0t: unexpected box, expected none, actual %h", $time, box);
        end else begin
          want = pending_boxes.pop_front();
          check_field("left_col",    32'(want.left_col),    32'(box.left_col));
          check_field("top_row",     32'(want.top_row),     32'(box.top_row));
          check_field("right_col",   32'(want.right_col),   32'(box.right_col));
          check_field("bottom_row",  32'(want.bottom_row),  32'(box.bottom_row));
          check_field("empty_frame", 32'(want.empty_frame), 32'(box.empty_frame));
          check_field("no_trim",     32'(want.no_trim),     32'(box.no_trim));
        end
      end
      if (pix_fire) begin
        px_accepted++;
        track_pixel(pixel);
      end
    end
  end

  // Pixel driver: hold a stalled transaction, otherwise idle or take the next pixel
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        pixel       <= pixel_feed.pop_front();
        pixel_valid <= 1'b1;
        if (gaps_on && $urandom_range(0, 99) < 25) gap_left = pick_idle();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Box receiver: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (rst) begin
      box_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      box_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      box_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = pick_idle() - 1;
      box_stall <= 1'b1;
    end else begin
      box_stall <= 1'b0;
    end
  end

  task automatic push_px(pixel_t p);
    pixel_feed.push_back(p);
    px_pushed++;
  endtask

  task automatic wait_idle();
    while (px_accepted != px_pushed || pending_boxes.size() != 0) @(posedge clk);
    // let a pixel with no result clear the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = val[DIM_REG_W-1:0];
      REG_FRAME_HEIGHT: reg_height = val[DIM_REG_W-1:0];
      REG_SIDE_MASK:    reg_mask   = val[3:0];
      REG_MATCH_MODE:   reg_mode   = val[0];
      REG_KEY_COLOR:    reg_key    = val;
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [DIM_REG_W-1:0] w, logic [DIM_REG_W-1:0] h,
                          logic [3:0] m, logic mode, logic [31:0] k);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH,  CFG_DATA_W'(w));
    cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    cfg_write(REG_SIDE_MASK,    CFG_DATA_W'(m));
    cfg_write(REG_MATCH_MODE,   CFG_DATA_W'(mode));
    cfg_write(REG_KEY_COLOR,    k);
    cfg_release();
    settings++;
  endtask

  task automatic random_phase(ref int rand_px);
    logic [DIM_REG_W-1:0] w;
    logic [DIM_REG_W-1:0] h;
    logic [3:0]           m;
    logic [31:0]          k;
    int                   r;
    int                   size;
    int                   frames;
    int                   dens;
    r = $urandom_range(0, 99);
    w = (r < 70) ? DIM_REG_W'($urandom_range(1, 6)) :
        (r < 95) ? DIM_REG_W'($urandom_range(7, 24)) : '0;
    r = $urandom_range(0, 99);
    h = (r < 70) ? DIM_REG_W'($urandom_range(1, 6)) :
        (r < 95) ? DIM_REG_W'($urandom_range(7, 12)) : '0;
    r = $urandom_range(0, 99);
    m = (r < 20) ? 4'h0 : (r < 40) ? 4'hF : 4'($urandom);
    r = $urandom_range(0, 99);
    k = (r < 15) ? 32'h0 : (r < 30) ? 32'hFFFF_FFFF : $urandom;
    set_regs(w, h, m, $urandom_range(0, 1) ? MODE_KEY : MODE_ALPHA, k);
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    size   = int'(eff_dim(w)) * int'(eff_dim(h));
    frames = $urandom_range(1, 4);
    if (size * frames > 250) frames = 1;
    for (int f = 0; f < frames; f++) begin
      r = $urandom_range(0, 99);
      dens = (r < 15) ? 0 : (r < 25) ? 100 : $urandom_range(3, 50);
      for (int i = 0; i < size; i++) begin
        push_px(make_pixel($urandom_range(0, 99) < dens));
        rand_px++;
      end
      // pause the source until every box so far is back
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    // leave a frame half done so the next register change lands mid-frame
    if (size > 1 && $urandom_range(0, 4) == 0) begin
      r = $urandom_range(1, size - 1);
      for (int i = 0; i < r; i++) begin
        push_px(make_pixel($urandom_range(0, 99) < 30));
        rand_px++;
      end
    end
  endtask

  initial begin : stimulus
    int rand_px;
    int box_base;
    rand_px = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: every pixel is a one-pixel frame
    push_px(32'h0000_0000);
    push_px(32'hFFFF_FFFF);
    push_px(32'hFFFF_FF00);
    push_px(32'h0000_0001);

    // Box spanning two rows, all sides enabled
    set_regs(3, 2, 4'hF, MODE_ALPHA, 32'h0);
    push_px(32'h0102_0300);
    push_px(32'h0000_0080);
    push_px(32'hFFFF_FF00);
    push_px(32'h0000_0000);
    push_px(32'h7F7F_7F00);
    push_px(32'h00FF_00FF);

    // All sides disabled
    set_regs(2, 1, 4'h0, MODE_ALPHA, 32'h0);
    push_px(32'h0000_0000);
    push_px(32'h0000_0010);

    // Key compare: equal is background, any differing byte is content
    set_regs(2, 2, 4'hF, MODE_KEY, 32'h1234_5678);
    push_px(32'h1234_5678);
    push_px(32'h1234_5678);
    push_px(32'h9234_5678);
    push_px(32'h1234_5679);

    // Zero dimensions act as one
    set_regs(0, 0, 4'h5, MODE_ALPHA, 32'h0);
    push_px(32'hFF00_00FF);

    // Shrink the width mid-frame; the kept column ends the row and the frame
    set_regs(4, 2, 4'hF, MODE_ALPHA, 32'h0);
    push_px(32'h0000_0000);
    push_px(32'h0000_00FF);
    push_px(32'h0000_0000);
    push_px(32'h0000_0000);
    push_px(32'h0000_0022);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    cfg_release();
    settings++;
    push_px(32'h0000_0000);

    // Long frames: one long row, then one tall column
    set_regs(64, 1, 4'hF, MODE_ALPHA, 32'h0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 64; i++)
      push_px(make_pixel(i == 63 || $urandom_range(0, 15) == 0));
    set_regs(1, 64, 4'b1010, MODE_KEY, $urandom);
    for (int i = 0; i < 64; i++)
      push_px(make_pixel(i == 63 || $urandom_range(0, 15) == 0));

    // Hold off the receiver long enough that the block stalls the source
    set_regs(1, 1, 4'hF, MODE_ALPHA, 32'h0);
    holdoff_left = 300;
    for (int i = 0; i < 80; i++) push_px(make_pixel($urandom_range(0, 1) == 1));
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    box_base = boxes_seen;
    while (rand_px < 800 || boxes_seen - box_base < 48) random_phase(rand_px);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d pixels and %0d boxes over %0d register settings.",
             px_accepted, boxes_seen, settings);
    $display("Source was stalled on %0d cycles; %0d mismatches.", src_stalls, errors);
    if (errors == 0 && pending_boxes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout with %0d boxes still expected", pending_boxes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
